@@ rtl/meq_pkg.sv @@
package meq_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IdxW   = 2;

  // Stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 72;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegCooldown = 2'd0;
  localparam logic [IdxW-1:0] RegLevel    = 2'd1;
  localparam logic [IdxW-1:0] RegMode     = 2'd2;

  // Retrigger modes
  localparam logic ModeRepeat   = 1'b0;
  localparam logic ModeDiscrete = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] cooldown_ms;
    logic             active_level;
    logic             retrigger_mode;
  } cfg_t;

  typedef struct packed {
    logic             sensor_level;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              event_started;
    logic              event_ended;
    logic              cooldown_done;
    logic              motion_active;
    logic              cooling_down;
    logic [CountW-1:0] detection_total;
    logic [TimeW-1:0]  last_width_ms;
  } out_item_t;

endpackage

@@ rtl/meq_cfg.sv @@
module meq_cfg
  import meq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output cfg_t            cfg
);

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCooldown: cfg.cooldown_ms    <= cfg_data[TimeW-1:0];
        RegLevel:    cfg.active_level   <= cfg_data[0];
        RegMode:     cfg.retrigger_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/meq_eval.sv @@
module meq_eval
  import meq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      load,
  input  in_item_t  item,
  output out_item_t result
);

  logic              motion_flag;
  logic              holdoff_flag;
  logic [TimeW-1:0]  detect_start_time;
  logic [TimeW-1:0]  last_idle_time;
  logic [CountW-1:0] detect_count;
  logic [TimeW-1:0]  event_width_reg;

  logic              motion_flag_next;
  logic              holdoff_flag_next;
  logic [TimeW-1:0]  detect_start_time_next;
  logic [TimeW-1:0]  last_idle_time_next;
  logic [CountW-1:0] detect_count_next;
  logic [TimeW-1:0]  event_width_reg_next;

  logic [TimeW-1:0] elapsed;
  logic             expired;
  logic             hold_mid;
  logic             line_active;
  logic             started;
  logic             ended;

  // Holdoff expiry, then line sampling once holdoff is clear
  always_comb begin
    elapsed     = item.now_ms - detect_start_time;
    expired     = holdoff_flag && (elapsed > cfg.cooldown_ms);
    hold_mid    = holdoff_flag && !expired;
    line_active = (item.sensor_level == cfg.active_level);
    started     = !hold_mid && line_active &&
                  ((cfg.retrigger_mode == ModeRepeat) || !motion_flag);
    ended       = !hold_mid && !line_active && motion_flag;

    motion_flag_next       = hold_mid ? motion_flag : line_active;
    holdoff_flag_next      = hold_mid || started;
    detect_start_time_next = started ? item.now_ms : detect_start_time;
    last_idle_time_next    = (!hold_mid && !line_active) ? item.now_ms : last_idle_time;
    detect_count_next      = (started && (detect_count != '1)) ?
                             detect_count + 1'b1 : detect_count;
    event_width_reg_next   = ended ? (item.now_ms - last_idle_time) : event_width_reg;

    result.event_started   = started;
    result.event_ended     = ended;
    result.cooldown_done   = expired;
    result.motion_active   = motion_flag_next;
    result.cooling_down    = holdoff_flag_next;
    result.detection_total = detect_count_next;
    result.last_width_ms   = event_width_reg_next;
  end

  // Detector state, advanced once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_flag       <= 1'b0;
      holdoff_flag      <= 1'b0;
      detect_start_time <= '0;
      last_idle_time    <= '0;
      detect_count      <= '0;
      event_width_reg   <= '0;
    end else if (load) begin
      motion_flag       <= motion_flag_next;
      holdoff_flag      <= holdoff_flag_next;
      detect_start_time <= detect_start_time_next;
      last_idle_time    <= last_idle_time_next;
      detect_count      <= detect_count_next;
      event_width_reg   <= event_width_reg_next;
    end
  end

  // Count never goes backward
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> detect_count >= $past(detect_count))
    else $error("detection count decreased");

  // A new detection always opens a holdoff window
  a_start_holds: assert property (@(posedge clk) disable iff (rst)
    load && started |=> holdoff_flag && motion_flag)
    else $error("detection without holdoff");

  // While holdoff runs, the line can neither start nor end an event
  a_hold_quiet: assert property (@(posedge clk) disable iff (rst)
    hold_mid |-> !started && !ended)
    else $error("line sampled during holdoff");

endmodule

@@ rtl/motion_event_qualifier_core.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   40     tdata: sensor_level, now_ms
// m_axis    out  72     tdata: event flags, detection_total, last_width_ms
// cfg       in   2+32   cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle sustained while m_axis is ready; a beat accepted on s_axis
// passes the input register, then evaluation into the result register, to m_axis.
// The state update is a 32-bit subtract and compare plus flag logic.
// rst (synchronous) clears configuration, detector state and the valid flags of both registers.
// A stalled m_axis holds its beat; s_axis still takes one more beat into the
// input register, then tready drops until the result register drains.
module motion_event_qualifier_core
  import meq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // cfg
  input  logic                cfg_we,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  // s_axis
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] sensor_level, [32:1] now_ms, [39:33] zero
  // m_axis
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] event_started, [1] event_ended,
                                              // [2] cooldown_done, [3] motion_active,
                                              // [4] cooling_down, [36:5] detection_total,
                                              // [68:37] last_width_ms, [71:69] zero
);

  cfg_t      cfg;
  in_item_t  in_item;
  logic      in_valid;
  out_item_t result;
  out_item_t out_item;
  logic      out_valid;
  logic      advance;

  meq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held beat into the result register when that slot is free
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.sensor_level <= s_axis_tdata[0];
      in_item.now_ms       <= s_axis_tdata[TimeW:1];
    end
  end

  meq_eval u_eval (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .load   (advance),
    .item   (in_item),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000,
                          out_item.last_width_ms,
                          out_item.detection_total,
                          out_item.cooling_down,
                          out_item.motion_active,
                          out_item.cooldown_done,
                          out_item.event_ended,
                          out_item.event_started};

  // A started beat leaves motion and holdoff set and a nonzero count
  a_start_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.event_started |->
      out_item.motion_active && out_item.cooling_down && (out_item.detection_total != '0))
    else $error("started beat with inconsistent flags");

  // An ended beat clears motion and cannot be in holdoff
  a_end_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.event_ended |->
      !out_item.motion_active && !out_item.cooling_down && !out_item.event_started)
    else $error("ended beat with inconsistent flags");

  // Expiry without a same-beat retrigger leaves holdoff clear
  a_expire_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.cooldown_done && !out_item.event_started |->
      !out_item.cooling_down)
    else $error("holdoff still set after expiry");

endmodule
